[design/oriented_box_world_bounds_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the world-bounds transform design
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_WORLD_BOUNDS_MACROS_SVH
`define ORIENTED_BOX_WORLD_BOUNDS_MACROS_SVH

// same-cycle implication, disabled during reset
`define OBWB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define OBWB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/obwb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obwb_pkg
// Shared widths, codes, control struct and saturation helper for the
// oriented-box world-bounds transform.
// ----------------------------------------------------------------------------
package obwb_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int AXES       = 3;

    localparam int MARGIN_W = DATA_WIDTH - 1;
    // doubled center and doubled half extent
    localparam int C2_W     = DATA_WIDTH + 1;
    localparam int H2_W     = DATA_WIDTH + 3;
    // operand split for the partial products
    localparam int SPLIT    = DATA_WIDTH / 2;
    localparam int CPH_W    = C2_W - SPLIT + DATA_WIDTH;
    localparam int CPL_W    = SPLIT + 1 + DATA_WIDTH;
    localparam int HPH_W    = H2_W - SPLIT + DATA_WIDTH + 1;
    localparam int HPL_W    = SPLIT + 1 + DATA_WIDTH + 1;
    localparam int ACC_W    = H2_W + DATA_WIDTH + 3;
    localparam int SH       = FRAC_BITS + 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BOX  = 1'b1;
    localparam logic [1:0] ROW_TRANSLATION = 2'd3;

    localparam logic signed [DATA_WIDTH-1:0] ONE_Q = DATA_WIDTH'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_UP = (ACC_W'(1) <<< SH) - ACC_W'(1);
    localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
        logic ld_d;
    } lane_ctl_t;

    // floor-divide by 2^SH, then clamp to the signed output range
    function automatic logic signed [DATA_WIDTH-1:0] sat_shift(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-SH-1:0] s;
        logic all_ones;
        logic all_zeros;
        s = v[ACC_W-1:SH];
        all_ones  = &s[ACC_W-SH-1:DATA_WIDTH-1];
        all_zeros = ~|s[ACC_W-SH-1:DATA_WIDTH-1];
        if (all_ones || all_zeros)
        begin
            return $signed(s[DATA_WIDTH-1:0]);
        end
        else if (s[ACC_W-SH-1])
        begin
            return SAT_MIN;
        end
        else
        begin
            return SAT_MAX;
        end
    endfunction

endpackage

[design/obwb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obwb_req_if / obwb_rsp_if
// Valid/ready channels for request items and world-box result items.
// ----------------------------------------------------------------------------
interface obwb_req_if;
    logic valid;
    logic ready;
    logic op;
    logic [1:0] row_index;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] elem_x;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] elem_y;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] elem_z;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] lo_x;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] lo_y;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] lo_z;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] hi_x;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] hi_y;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] hi_z;

    modport source (
        output valid, op, row_index, elem_x, elem_y, elem_z,
               lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
        input  ready
    );
    modport sink (
        input  valid, op, row_index, elem_x, elem_y, elem_z,
               lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
        output ready
    );
endinterface

interface obwb_rsp_if;
    logic valid;
    logic ready;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] world_lo_x;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] world_lo_y;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] world_lo_z;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] world_hi_x;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] world_hi_y;
    logic signed [obwb_pkg::DATA_WIDTH-1:0] world_hi_z;

    modport source (
        output valid, world_lo_x, world_lo_y, world_lo_z,
               world_hi_x, world_hi_y, world_hi_z,
        input  ready
    );
    modport sink (
        input  valid, world_lo_x, world_lo_y, world_lo_z,
               world_hi_x, world_hi_y, world_hi_z,
        output ready
    );
endinterface

[design/oriented_box_world_bounds.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_world_bounds
// Throughput: one item per cycle unless rsp.ready stalls the pipeline; a load
// item takes one input slot, no result. Three axis lanes run in parallel; the
// multiply/accumulate pipeline sets depth.
// Reset: basis to identity, translation and margin to zero, pipeline empty.
// ----------------------------------------------------------------------------
`include "oriented_box_world_bounds_macros.svh"

module oriented_box_world_bounds (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [obwb_pkg::MARGIN_W-1:0]        cfg_wr_data,
    obwb_req_if.sink                             req,
    obwb_rsp_if.source                           rsp
);

    logic [obwb_pkg::MARGIN_W-1:0]               margin_reg;
    logic signed [obwb_pkg::DATA_WIDTH-1:0]      basis_reg [obwb_pkg::AXES][obwb_pkg::AXES];
    logic signed [obwb_pkg::DATA_WIDTH-1:0]      trans_reg [obwb_pkg::AXES];

    logic v1_reg, va_reg, vb_reg, vc_reg, vd_reg, vo_reg;
    logic ld_1, ld_a, ld_b, ld_c, ld_d, ld_o;
    logic load_fire;
    obwb_pkg::lane_ctl_t lane_ctl;

    logic signed [obwb_pkg::DATA_WIDTH-1:0]      lo_in   [obwb_pkg::AXES];
    logic signed [obwb_pkg::DATA_WIDTH-1:0]      hi_in   [obwb_pkg::AXES];
    logic signed [obwb_pkg::DATA_WIDTH-1:0]      elem_in [obwb_pkg::AXES];
    logic signed [obwb_pkg::C2_W-1:0]            c2_next [obwb_pkg::AXES];
    logic signed [obwb_pkg::H2_W-1:0]            h2_next [obwb_pkg::AXES];

    logic                                        op1_reg;
    logic [1:0]                                  row1_reg;
    logic signed [obwb_pkg::DATA_WIDTH-1:0]      elem1_reg [obwb_pkg::AXES];
    logic signed [obwb_pkg::C2_W-1:0]            c2_1_reg  [obwb_pkg::AXES];
    logic signed [obwb_pkg::H2_W-1:0]            h2_1_reg  [obwb_pkg::AXES];

    logic signed [obwb_pkg::DATA_WIDTH-1:0]      col    [obwb_pkg::AXES][obwb_pkg::AXES];
    logic signed [obwb_pkg::ACC_W-1:0]           lo_sum [obwb_pkg::AXES];
    logic signed [obwb_pkg::ACC_W-1:0]           hi_sum [obwb_pkg::AXES];

    logic signed [obwb_pkg::DATA_WIDTH-1:0]      wlo_reg [obwb_pkg::AXES];
    logic signed [obwb_pkg::DATA_WIDTH-1:0]      whi_reg [obwb_pkg::AXES];

    // stage handshake: a stage loads when empty or when its successor loads
    always_comb
    begin
        ld_o = !vo_reg || rsp.ready;
        ld_d = !vd_reg || ld_o;
        ld_c = !vc_reg || ld_d;
        ld_b = !vb_reg || ld_c;
        ld_a = !va_reg || ld_b;
        // a load item retires from the input stage without entering the lanes
        ld_1 = !v1_reg || (op1_reg == obwb_pkg::OP_LOAD) || ld_a;
        load_fire = v1_reg && (op1_reg == obwb_pkg::OP_LOAD);
        lane_ctl.ld_a = ld_a;
        lane_ctl.ld_b = ld_b;
        lane_ctl.ld_c = ld_c;
        lane_ctl.ld_d = ld_d;
    end

    assign req.ready = ld_1;

    always_comb
    begin
        lo_in[0]   = req.lo_x;
        lo_in[1]   = req.lo_y;
        lo_in[2]   = req.lo_z;
        hi_in[0]   = req.hi_x;
        hi_in[1]   = req.hi_y;
        hi_in[2]   = req.hi_z;
        elem_in[0] = req.elem_x;
        elem_in[1] = req.elem_y;
        elem_in[2] = req.elem_z;
        for (int i = 0; i < obwb_pkg::AXES; i++)
        begin
            c2_next[i] = obwb_pkg::C2_W'(lo_in[i]) + obwb_pkg::C2_W'(hi_in[i]);
            h2_next[i] = obwb_pkg::H2_W'(hi_in[i]) - obwb_pkg::H2_W'(lo_in[i])
                       + $signed({3'b000, margin_reg, 1'b0});
        end
    end

    // lane j reads column j of the basis
    always_comb
    begin
        for (int j = 0; j < obwb_pkg::AXES; j++)
        begin
            for (int i = 0; i < obwb_pkg::AXES; i++)
            begin
                col[j][i] = basis_reg[i][j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            va_reg     <= 1'b0;
            vb_reg     <= 1'b0;
            vc_reg     <= 1'b0;
            vd_reg     <= 1'b0;
            vo_reg     <= 1'b0;
            margin_reg <= '0;
            for (int i = 0; i < obwb_pkg::AXES; i++)
            begin
                trans_reg[i] <= '0;
                for (int j = 0; j < obwb_pkg::AXES; j++)
                begin
                    basis_reg[i][j] <= (i == j) ? obwb_pkg::ONE_Q : '0;
                end
            end
        end
        else
        begin
            if (ld_1)
            begin
                v1_reg <= req.valid;
            end
            if (ld_a)
            begin
                va_reg <= v1_reg && (op1_reg == obwb_pkg::OP_BOX);
            end
            if (ld_b)
            begin
                vb_reg <= va_reg;
            end
            if (ld_c)
            begin
                vc_reg <= vb_reg;
            end
            if (ld_d)
            begin
                vd_reg <= vc_reg;
            end
            if (ld_o)
            begin
                vo_reg <= vd_reg;
            end
            if (cfg_wr_en)
            begin
                margin_reg <= cfg_wr_data;
            end
            // boxes ahead have already read the transform; later ones see the new row
            if (load_fire)
            begin
                for (int k = 0; k < obwb_pkg::AXES; k++)
                begin
                    if (row1_reg == obwb_pkg::ROW_TRANSLATION)
                    begin
                        trans_reg[k] <= elem1_reg[k];
                    end
                    else
                    begin
                        basis_reg[row1_reg][k] <= elem1_reg[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_1)
        begin
            op1_reg  <= req.op;
            row1_reg <= req.row_index;
            for (int i = 0; i < obwb_pkg::AXES; i++)
            begin
                elem1_reg[i] <= elem_in[i];
                c2_1_reg[i]  <= c2_next[i];
                h2_1_reg[i]  <= h2_next[i];
            end
        end
        // merge the lanes into one result item
        if (ld_o)
        begin
            for (int j = 0; j < obwb_pkg::AXES; j++)
            begin
                wlo_reg[j] <= obwb_pkg::sat_shift(lo_sum[j]);
                whi_reg[j] <= obwb_pkg::sat_shift(hi_sum[j]);
            end
        end
    end

    for (genvar j = 0; j < obwb_pkg::AXES; j++)
    begin : g_lane
        obwb_lane u_lane (
            .clk    (clk),
            .ctl    (lane_ctl),
            .c2     (c2_1_reg),
            .h2     (h2_1_reg),
            .col    (col[j]),
            .trans  (trans_reg[j]),
            .lo_sum (lo_sum[j]),
            .hi_sum (hi_sum[j])
        );
    end

    assign rsp.valid      = vo_reg;
    assign rsp.world_lo_x = wlo_reg[0];
    assign rsp.world_lo_y = wlo_reg[1];
    assign rsp.world_lo_z = wlo_reg[2];
    assign rsp.world_hi_x = whi_reg[0];
    assign rsp.world_hi_y = whi_reg[1];
    assign rsp.world_hi_z = whi_reg[2];

    `OBWB_ASSERT_NEXT(a_item_enters, clk, rst_n, req.valid && req.ready, v1_reg, "accepted item not in input stage")
    `OBWB_ASSERT_NEXT(a_load_no_result, clk, rst_n, load_fire && ld_a, !va_reg, "load item entered the lanes")
    `OBWB_ASSERT_NEXT(a_trans_write, clk, rst_n, load_fire && (row1_reg == obwb_pkg::ROW_TRANSLATION), trans_reg[2] == $past(elem1_reg[2]), "translation row not stored")
    `OBWB_ASSERT_NEXT(a_stage_holds, clk, rst_n, vd_reg && !ld_o, vd_reg, "stalled result dropped")
    `OBWB_ASSERT_NOW(a_ready_when_free, clk, rst_n, !v1_reg, req.ready, "input stage empty but not ready")

endmodule

[design/obwb_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obwb_lane
// One output axis: dot products of the doubled center with a basis column
// and of the doubled half extent with its absolute value, plus translation.
// ----------------------------------------------------------------------------
module obwb_lane (
    input  logic                                     clk,
    input  obwb_pkg::lane_ctl_t                      ctl,
    input  logic signed [obwb_pkg::C2_W-1:0]         c2    [obwb_pkg::AXES],
    input  logic signed [obwb_pkg::H2_W-1:0]         h2    [obwb_pkg::AXES],
    input  logic signed [obwb_pkg::DATA_WIDTH-1:0]   col   [obwb_pkg::AXES],
    input  logic signed [obwb_pkg::DATA_WIDTH-1:0]   trans,
    output logic signed [obwb_pkg::ACC_W-1:0]        lo_sum,
    output logic signed [obwb_pkg::ACC_W-1:0]        hi_sum
);

    logic [obwb_pkg::DATA_WIDTH-1:0]             abs_col [obwb_pkg::AXES];
    logic signed [obwb_pkg::CPH_W-1:0]           cph_next [obwb_pkg::AXES];
    logic signed [obwb_pkg::CPL_W-1:0]           cpl_next [obwb_pkg::AXES];
    logic signed [obwb_pkg::HPH_W-1:0]           hph_next [obwb_pkg::AXES];
    logic signed [obwb_pkg::HPL_W-1:0]           hpl_next [obwb_pkg::AXES];

    logic signed [obwb_pkg::CPH_W-1:0]           cph_reg [obwb_pkg::AXES];
    logic signed [obwb_pkg::CPL_W-1:0]           cpl_reg [obwb_pkg::AXES];
    logic signed [obwb_pkg::HPH_W-1:0]           hph_reg [obwb_pkg::AXES];
    logic signed [obwb_pkg::HPL_W-1:0]           hpl_reg [obwb_pkg::AXES];
    logic signed [obwb_pkg::DATA_WIDTH-1:0]      ta_reg;

    logic signed [obwb_pkg::ACC_W-1:0]           cp_reg [obwb_pkg::AXES];
    logic signed [obwb_pkg::ACC_W-1:0]           hp_reg [obwb_pkg::AXES];
    logic signed [obwb_pkg::DATA_WIDTH-1:0]      tb_reg;

    logic signed [obwb_pkg::ACC_W-1:0]           wc_reg;
    logic signed [obwb_pkg::ACC_W-1:0]           wh_reg;
    logic signed [obwb_pkg::ACC_W-1:0]           lo_reg;
    logic signed [obwb_pkg::ACC_W-1:0]           hi_reg;

    // split each wide operand into a signed high part and an unsigned low part
    always_comb
    begin
        for (int i = 0; i < obwb_pkg::AXES; i++)
        begin
            abs_col[i] = col[i][obwb_pkg::DATA_WIDTH-1] ? (-col[i]) : col[i];
            cph_next[i] = $signed(c2[i][obwb_pkg::C2_W-1:obwb_pkg::SPLIT]) * col[i];
            cpl_next[i] = $signed({1'b0, c2[i][obwb_pkg::SPLIT-1:0]}) * col[i];
            hph_next[i] = $signed(h2[i][obwb_pkg::H2_W-1:obwb_pkg::SPLIT])
                        * $signed({1'b0, abs_col[i]});
            hpl_next[i] = $signed({1'b0, h2[i][obwb_pkg::SPLIT-1:0]})
                        * $signed({1'b0, abs_col[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_a)
        begin
            for (int i = 0; i < obwb_pkg::AXES; i++)
            begin
                cph_reg[i] <= cph_next[i];
                cpl_reg[i] <= cpl_next[i];
                hph_reg[i] <= hph_next[i];
                hpl_reg[i] <= hpl_next[i];
            end
            ta_reg <= trans;
        end
        if (ctl.ld_b)
        begin
            for (int i = 0; i < obwb_pkg::AXES; i++)
            begin
                cp_reg[i] <= (obwb_pkg::ACC_W'(cph_reg[i]) <<< obwb_pkg::SPLIT)
                           + obwb_pkg::ACC_W'(cpl_reg[i]);
                hp_reg[i] <= (obwb_pkg::ACC_W'(hph_reg[i]) <<< obwb_pkg::SPLIT)
                           + obwb_pkg::ACC_W'(hpl_reg[i]);
            end
            tb_reg <= ta_reg;
        end
        if (ctl.ld_c)
        begin
            wc_reg <= cp_reg[0] + cp_reg[1] + cp_reg[2]
                    + (obwb_pkg::ACC_W'(tb_reg) <<< obwb_pkg::SH);
            wh_reg <= hp_reg[0] + hp_reg[1] + hp_reg[2];
        end
        if (ctl.ld_d)
        begin
            lo_reg <= wc_reg - wh_reg;
            // bias up so the later floor rounds the maximum toward plus infinity
            hi_reg <= wc_reg + wh_reg + obwb_pkg::ROUND_UP;
        end
    end

    assign lo_sum = lo_reg;
    assign hi_sum = hi_reg;

endmodule
